/* rtl/crc_framed_command_checker_assert.svh */
// Assertion macros for the frame command checker.
// Needs a clock named i_clk and an active low reset named i_rst_n in scope.
`ifndef CRC_FRAMED_COMMAND_CHECKER_ASSERT_SVH
`define CRC_FRAMED_COMMAND_CHECKER_ASSERT_SVH

// same-cycle implication
`define CFCC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CFCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/cfcc_pkg.sv */
// Shared constants, result type and CRC-16/MODBUS byte update.
// No dependencies.
package cfcc_pkg;

    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam logic [7:0]  OPEN_COMMAND = 8'd100;
    localparam logic [7:0]  TOKEN_LEN    = 8'd32;
    localparam logic [5:0]  OFFSET_OPEN  = 6'd3;
    localparam logic [5:0]  OFFSET_TOKEN = 6'd36;
    localparam int          TOKEN_WORDS  = 4;

    localparam logic [2:0] ST_DELIVER        = 3'd0;
    localparam logic [2:0] ST_TOKEN_MISMATCH = 3'd1;
    localparam logic [2:0] ST_BAD_TOKEN_LEN  = 3'd2;
    localparam logic [2:0] ST_CRC_FAIL       = 3'd3;
    localparam logic [2:0] ST_TOO_SHORT      = 3'd4;

    localparam logic [2:0] CFG_TOKEN_0       = 3'd0;
    localparam logic [2:0] CFG_TOKEN_1       = 3'd1;
    localparam logic [2:0] CFG_TOKEN_2       = 3'd2;
    localparam logic [2:0] CFG_TOKEN_3       = 3'd3;
    localparam logic [2:0] CFG_TOKEN_PRESENT = 3'd4;

    // byte 0 of the token is element 0
    typedef logic [0:31][7:0] t_token;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  command;
        logic [5:0]  payload_offset;
        logic [15:0] payload_length;
        logic        reply_needed;
        logic [15:0] reply_crc;
    } t_result;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* rtl/crc_framed_command_checker.sv */
// An accepted byte is held in the input register; the single-pass frame logic gives a verdict on a
// chunk end byte, registered in the result register, or in the skid stage while the output stalls.
// Throughput: one byte per cycle while the skid stage is empty; a full skid stage stalls the input.
// Reset (i_rst_n low, synchronous): frame state cleared, CRC at 0xFFFF, token and
// token_present zero, input and output stages empty.
// Depends on cfcc_pkg, cfcc_frame, cfcc_outbuf, crc_framed_command_checker_assert.svh.
`include "crc_framed_command_checker_assert.svh"
module crc_framed_command_checker
    import cfcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_chunk_end,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [7:0]  o_command,
    output logic [5:0]  o_payload_offset,
    output logic [15:0] o_payload_length,
    output logic        o_reply_needed,
    output logic [15:0] o_reply_crc
);

    logic [TOKEN_WORDS-1:0][63:0] r_tok;
    logic       r_tok_present;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;
    logic       w_full;
    logic       w_step;
    logic       w_emit;
    t_result    w_result;
    t_result    w_out;
    t_token     w_token;

    assign o_cfg_ready = 1'b1;
    assign w_token     = {r_tok[0], r_tok[1], r_tok[2], r_tok[3]};
    assign w_step      = r_in_valid && !w_full;
    assign o_in_ready  = !r_in_valid || !w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok         <= '0;
            r_tok_present <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TOKEN_0:       r_tok[0] <= i_cfg_data;
                CFG_TOKEN_1:       r_tok[1] <= i_cfg_data;
                CFG_TOKEN_2:       r_tok[2] <= i_cfg_data;
                CFG_TOKEN_3:       r_tok[3] <= i_cfg_data;
                CFG_TOKEN_PRESENT: r_tok_present <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_data_byte;
            r_in_end  <= i_chunk_end;
        end
    end

    cfcc_frame u_frame (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_step),
        .i_data_byte     (r_in_byte),
        .i_chunk_end     (r_in_end),
        .i_token         (w_token),
        .i_token_present (r_tok_present),
        .o_emit          (w_emit),
        .o_result        (w_result)
    );

    cfcc_outbuf u_outbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_emit),
        .i_result (w_result),
        .o_full   (w_full),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (w_out)
    );

    assign o_status         = w_out.status;
    assign o_command        = w_out.command;
    assign o_payload_offset = w_out.payload_offset;
    assign o_payload_length = w_out.payload_length;
    assign o_reply_needed   = w_out.reply_needed;
    assign o_reply_crc      = w_out.reply_crc;

    `CFCC_ASSERT_NOW(a_skid_behind_out, w_full, o_out_valid,
        "skid holds a result but output is empty")
    `CFCC_ASSERT_NOW(a_emit_on_end, w_emit, w_step && r_in_end,
        "verdict without a chunk end byte")
    `CFCC_ASSERT_NOW(a_reject_no_payload, o_out_valid && o_status != ST_DELIVER,
        o_payload_length == 16'd0 && o_payload_offset == 6'd0,
        "payload fields set on a rejected frame")
    `CFCC_ASSERT_NOW(a_reply_status, o_out_valid && o_reply_needed,
        o_status == ST_TOKEN_MISMATCH || o_status == ST_BAD_TOKEN_LEN,
        "reply flagged for a status that needs none")
    `CFCC_ASSERT_NEXT(a_stall_keeps_result, o_out_valid && !i_out_ready, o_out_valid,
        "result dropped while stalled")

endmodule

/* rtl/cfcc_frame.sv */
// Frame state, on-the-fly CRC and token compare, and the frame verdict.
// Uses cfcc_pkg.
module cfcc_frame
    import cfcc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_data_byte,
    input  logic       i_chunk_end,
    input  t_token     i_token,
    input  logic       i_token_present,
    output logic       o_emit,
    output t_result    o_result
);

    logic [16:0] r_seen, n_seen;
    logic [15:0] r_len, n_len;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_cmd_crc, n_cmd_crc;
    logic [7:0]  r_cmd, n_cmd;
    logic [7:0]  r_toklen, n_toklen;
    logic        r_match, n_match;

    logic        cur_complete;
    logic        new_complete;
    logic [15:0] crc_upd;
    logic [5:0]  tok_pos;
    logic [15:0] rcrc;
    logic [2:0]  status;
    logic [5:0]  offset;

    assign tok_pos = r_seen[5:0] - 6'd4;
    assign crc_upd = crc_byte(r_crc, i_data_byte);

    always_comb begin
        n_seen    = r_seen;
        n_len     = r_len;
        n_crc     = r_crc;
        n_cmd_crc = r_cmd_crc;
        n_cmd     = r_cmd;
        n_toklen  = r_toklen;
        n_match   = r_match;
        cur_complete = (r_seen >= 17'd2) && (r_seen >= ({1'b0, r_len} + 17'd2));
        if (!cur_complete) begin
            if (r_seen == 17'd0) begin
                n_len = {i_data_byte, 8'h00};
            end else if (r_seen == 17'd1) begin
                n_len = {r_len[15:8], i_data_byte};
            end else begin
                n_crc = crc_upd;
                if (r_seen == 17'd2) begin
                    n_cmd     = i_data_byte;
                    n_cmd_crc = crc_upd;
                end else if (r_seen == 17'd3) begin
                    n_toklen = i_data_byte;
                end else if (r_seen < 17'd36 && i_token[tok_pos[4:0]] != i_data_byte) begin
                    n_match = 1'b0;
                end
            end
            n_seen = r_seen + 17'd1;
        end
        new_complete = (n_seen >= 17'd2) && (n_seen >= ({1'b0, n_len} + 17'd2));
    end

    always_comb begin
        offset = 6'd0;
        if (n_len < 16'd3) begin
            status = ST_TOO_SHORT;
        end else if (n_crc != 16'd0) begin
            status = ST_CRC_FAIL;
        end else if (n_cmd == OPEN_COMMAND) begin
            status = ST_DELIVER;
            offset = OFFSET_OPEN;
        end else if (n_toklen != TOKEN_LEN) begin
            status = ST_BAD_TOKEN_LEN;
        end else if (n_len < {10'd0, OFFSET_TOKEN}) begin
            status = ST_TOO_SHORT;
        end else if (!(i_token_present && n_match)) begin
            status = ST_TOKEN_MISMATCH;
        end else begin
            status = ST_DELIVER;
            offset = OFFSET_TOKEN;
        end
    end

    assign rcrc = crc_byte(n_cmd_crc, {5'd0, status});

    always_comb begin
        o_result.status         = status;
        o_result.command        = n_cmd;
        o_result.payload_offset = offset;
        o_result.payload_length = (status == ST_DELIVER) ? (n_len - {10'd0, offset}) : 16'd0;
        o_result.reply_needed   = (status == ST_TOKEN_MISMATCH) || (status == ST_BAD_TOKEN_LEN);
        o_result.reply_crc      = o_result.reply_needed ? {rcrc[7:0], rcrc[15:8]} : 16'd0;
    end

    assign o_emit = i_step && i_chunk_end && new_complete;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_emit) begin
            r_seen   <= 17'd0;
            r_len    <= 16'd0;
            r_crc    <= CRC_INIT;
            r_cmd    <= 8'd0;
            r_toklen <= 8'd0;
            r_match  <= 1'b1;
        end else if (i_step) begin
            r_seen   <= n_seen;
            r_len    <= n_len;
            r_crc    <= n_crc;
            r_cmd    <= n_cmd;
            r_toklen <= n_toklen;
            r_match  <= n_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_cmd_crc <= n_cmd_crc;
        end
    end

endmodule

/* rtl/cfcc_outbuf.sv */
// Result register with a skid stage behind it.
// Uses cfcc_pkg.
module cfcc_outbuf
    import cfcc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    take;

    assign take    = !r_out_valid || i_ready;
    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_load;
            end
        end else if (i_load) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= r_skid_valid ? r_skid : i_result;
        end else if (i_load) begin
            r_skid <= i_result;
        end
    end

endmodule

/* bench/crc_framed_command_checker_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for crc_framed_command_checker: frames built with valid or broken
// CRC, token and length fields are streamed byte by byte and every verdict is checked.
// Depends on cfcc_pkg and the checker RTL.
module crc_framed_command_checker_tb;
    import cfcc_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_link_byte;

    typedef enum int {FR_OPEN, FR_TOKEN_OK, FR_TOKEN_BAD, FR_TLEN_BAD, FR_TOKEN_CUT,
                      FR_NOISE, FR_TINY} t_frame_kind;
    typedef enum int {TOK_RANDOM, TOK_ONES, TOK_ZEROS} t_token_fill;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = CFG_TOKEN_0;
    logic [63:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = '0;
    logic        i_chunk_end = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_status;
    logic [7:0]  o_command;
    logic [5:0]  o_payload_offset;
    logic [15:0] o_payload_length;
    logic        o_reply_needed;
    logic [15:0] o_reply_crc;

    crc_framed_command_checker uut (.*);

    // link bytes waiting to be sent, and verdicts waiting to come out
    t_link_byte pending_bytes[$];
    t_result    expected_verdicts[$];
    int         bytes_owed = 0;
    int         faults = 0;
    logic       calm = 1'b0;
    int         in_hold = 0;
    int         out_hold = 0;

    // mirror of the configuration and of the frame in progress
    t_token      tok_copy = '0;
    logic        tok_on = 1'b0;
    logic [16:0] seen = '0;
    logic [15:0] flen = '0;
    logic [15:0] acc = CRC_INIT;
    logic [7:0]  cmd_seen = '0;
    logic [7:0]  tlen_seen = '0;
    logic        tok_ok = 1'b1;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("crc_framed_command_checker_tb NOT OK");
        $finish;
    end

    // CRC-16/MODBUS, one data bit at a time, LSB first
    function automatic logic [15:0] modbus_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        r = crc;
        for (int k = 0; k < 8; k++) begin
            if (r[0] ^ b[k]) begin
                r = (r >> 1) ^ CRC_POLY;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    function automatic void track_byte(input logic [7:0] b, input logic last);
        t_result     r;
        logic [15:0] c;
        logic        whole;
        whole = (seen >= 17'd2) && (seen >= {1'b0, flen} + 17'd2);
        if (!whole) begin
            if (seen == 17'd0) begin
                flen = {b, 8'h00};
            end else if (seen == 17'd1) begin
                flen[7:0] = b;
            end else begin
                acc = modbus_next(acc, b);
                if (seen == 17'd2) begin
                    cmd_seen = b;
                end else if (seen == 17'd3) begin
                    tlen_seen = b;
                end else if (seen < OFFSET_TOKEN && tok_copy[5'(seen - 17'd4)] != b) begin
                    tok_ok = 1'b0;
                end
            end
            seen = seen + 17'd1;
            whole = (seen >= 17'd2) && (seen >= {1'b0, flen} + 17'd2);
        end
        if (last && whole) begin
            r = '0;
            r.command = cmd_seen;
            if (flen < 16'd3) begin
                r.status = ST_TOO_SHORT;
            end else if (acc != 16'h0000) begin
                r.status = ST_CRC_FAIL;
            end else if (cmd_seen == OPEN_COMMAND) begin
                r.status = ST_DELIVER;
                r.payload_offset = OFFSET_OPEN;
            end else if (tlen_seen != TOKEN_LEN) begin
                r.status = ST_BAD_TOKEN_LEN;
            end else if (flen < OFFSET_TOKEN) begin
                r.status = ST_TOO_SHORT;
            end else if (!(tok_on && tok_ok)) begin
                r.status = ST_TOKEN_MISMATCH;
            end else begin
                r.status = ST_DELIVER;
                r.payload_offset = OFFSET_TOKEN;
            end
            if (r.status == ST_DELIVER) begin
                r.payload_length = flen - {10'b0, r.payload_offset};
            end
            if (r.status == ST_TOKEN_MISMATCH || r.status == ST_BAD_TOKEN_LEN) begin
                c = modbus_next(modbus_next(CRC_INIT, cmd_seen), {5'b0, r.status});
                r.reply_needed = 1'b1;
                r.reply_crc = {c[7:0], c[15:8]};
            end
            expected_verdicts.push_back(r);
            seen = '0;
            flen = '0;
            acc = CRC_INIT;
            cmd_seen = '0;
            tlen_seen = '0;
            tok_ok = 1'b1;
        end
    endfunction

    function automatic void cmp_field(input string what, input int unsigned want,
                                      input int unsigned got);
        if (want != got) begin
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, what, want, got);
            faults++;
        end
    endfunction

    // sender
    always @(posedge i_clk) begin
        t_link_byte nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                track_byte(i_data_byte, i_chunk_end);
                bytes_owed--;
            end
            if (!i_in_valid || o_in_ready) begin
                if (in_hold > 0) begin
                    in_hold--;
                    i_in_valid <= 1'b0;
                end else if (!calm && pending_bytes.size() != 0
                             && $urandom_range(0, 19) == 0) begin
                    in_hold = $urandom_range(0, 12);
                    i_in_valid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    nxt = pending_bytes.pop_front();
                    i_in_valid <= 1'b1;
                    i_data_byte <= nxt.data;
                    i_chunk_end <= nxt.last;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_verdicts.size() == 0) begin
                    $display("%0t result with none expected: status %0d command %0d",
                             $time, o_status, o_command);
                    faults++;
                end else begin
                    want = expected_verdicts.pop_front();
                    cmp_field("status", want.status, o_status);
                    cmp_field("command", want.command, o_command);
                    cmp_field("payload_offset", want.payload_offset, o_payload_offset);
                    cmp_field("payload_length", want.payload_length, o_payload_length);
                    cmp_field("reply_needed", want.reply_needed, o_reply_needed);
                    cmp_field("reply_crc", want.reply_crc, o_reply_crc);
                end
            end
            if (out_hold > 0) begin
                out_hold--;
                i_out_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 15) == 0) begin
                out_hold = $urandom_range(0, 12);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic void push_byte(input logic [7:0] b, input logic last);
        pending_bytes.push_back('{data: b, last: last});
        bytes_owed++;
    endfunction

    // builds one frame, returns the number of link bytes queued
    function automatic int queue_frame(input t_frame_kind kind, input logic [7:0] cmd,
                                       input int n, input bit bad_crc, input int trail,
                                       input int pct);
        logic [7:0]  body[$];
        logic [7:0]  tb;
        logic [7:0]  tl;
        logic [15:0] c;
        logic [15:0] len;
        int          nt;
        int          wrong;
        int          last_idx;
        if (kind == FR_TINY || kind == FR_NOISE) begin
            repeat (n) body.push_back(8'($urandom_range(0, 255)));
        end else begin
            body.push_back(kind == FR_OPEN ? OPEN_COMMAND : cmd);
            if (kind != FR_OPEN) begin
                if (kind == FR_TLEN_BAD) begin
                    do tl = 8'($urandom_range(0, 255)); while (tl == TOKEN_LEN);
                    body.push_back(tl);
                end else begin
                    body.push_back(TOKEN_LEN);
                    nt = (kind == FR_TOKEN_CUT) ? $urandom_range(0, 31) : 32;
                    wrong = (kind == FR_TOKEN_BAD) ? $urandom_range(0, 31) : 32;
                    for (int k = 0; k < nt; k++) begin
                        tb = tok_copy[5'(k)];
                        if (k == wrong) begin
                            tb = tb ^ 8'($urandom_range(1, 255));
                        end
                        body.push_back(tb);
                    end
                end
            end
            if (kind != FR_TOKEN_CUT) begin
                repeat (n) body.push_back(8'($urandom_range(0, 255)));
            end
        end
        if (kind != FR_TINY) begin
            c = CRC_INIT;
            foreach (body[i]) c = modbus_next(c, body[i]);
            if (bad_crc) begin
                c = c ^ (16'h0001 << $urandom_range(0, 15));
            end
            body.push_back(c[7:0]);
            body.push_back(c[15:8]);
        end
        len = 16'(body.size());
        body.push_front(len[7:0]);
        body.push_front(len[15:8]);
        last_idx = body.size() - 1;
        foreach (body[i]) begin
            push_byte(body[i], (i == last_idx) ? (trail == 0) : ($urandom_range(0, 99) < pct));
        end
        for (int t = 0; t < trail; t++) begin
            push_byte(8'($urandom_range(0, 255)), t == trail - 1);
        end
        return body.size() + trail;
    endfunction

    task automatic drain();
        while (bytes_owed != 0 || expected_verdicts.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        int base;
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_TOKEN_PRESENT: tok_on = val[0];
            CFG_TOKEN_0, CFG_TOKEN_1, CFG_TOKEN_2, CFG_TOKEN_3: begin
                base = idx * 8;
                for (int k = 0; k < 8; k++) tok_copy[5'(base + k)] = val[63 - 8 * k -: 8];
            end
            default: ;
        endcase
    endtask

    // settle the block, then rewrite every register
    task automatic load_token(input t_token_fill fill, input bit present);
        logic [63:0] w;
        drain();
        repeat (4) @(posedge i_clk);
        for (int i = 0; i < TOKEN_WORDS; i++) begin
            case (fill)
                TOK_ONES:  w = '1;
                TOK_ZEROS: w = '0;
                default:   w = {$urandom, $urandom};
            endcase
            write_reg(CFG_TOKEN_0 + 3'(i), w);
        end
        write_reg(CFG_TOKEN_PRESENT, {63'b0, present});
    endtask

    task automatic run_random(input int budget);
        int          spent;
        int          pick;
        int          trail;
        int          pct;
        logic [7:0]  cmd;
        spent = 0;
        while (spent < budget) begin
            if ($urandom_range(0, 11) == 0) begin
                drain();
            end
            pick = $urandom_range(0, 99);
            trail = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : 0;
            pct = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 30) : 0;
            do cmd = 8'($urandom_range(0, 255)); while (cmd == OPEN_COMMAND);
            if (pick < 30) begin
                spent += queue_frame(FR_TOKEN_OK, cmd, $urandom_range(0, 12), 0, trail, pct);
            end else if (pick < 45) begin
                spent += queue_frame(FR_OPEN, cmd,
                                     ($urandom_range(0, 9) == 0) ? $urandom_range(200, 300)
                                                                 : $urandom_range(0, 20),
                                     0, trail, pct);
            end else if (pick < 58) begin
                spent += queue_frame(FR_TOKEN_BAD, cmd, $urandom_range(0, 8), 0, trail, pct);
            end else if (pick < 67) begin
                spent += queue_frame(FR_TLEN_BAD, cmd, $urandom_range(0, 40), 0, trail, pct);
            end else if (pick < 75) begin
                spent += queue_frame(FR_TOKEN_CUT, cmd, 0, 0, trail, pct);
            end else if (pick < 83) begin
                spent += queue_frame(t_frame_kind'($urandom_range(FR_OPEN, FR_TOKEN_CUT)),
                                     cmd, $urandom_range(0, 10), 1, trail, pct);
            end else if (pick < 89) begin
                spent += queue_frame(FR_TINY, cmd, $urandom_range(0, 2), 0, trail, pct);
            end else begin
                spent += queue_frame(FR_NOISE, cmd, $urandom_range(1, 40),
                                     $urandom_range(0, 1) == 1, trail, pct);
            end
        end
    endtask

    initial begin
        int unused;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset configuration: no token stored
        unused = queue_frame(FR_TINY, 8'h00, 0, 0, 0, 0);
        unused = queue_frame(FR_TINY, 8'h00, 1, 0, 0, 50);
        unused = queue_frame(FR_TINY, 8'h00, 2, 0, 1, 0);
        unused = queue_frame(FR_OPEN, 8'h00, 0, 0, 3, 0);
        unused = queue_frame(FR_OPEN, 8'h00, 5, 1, 0, 0);
        unused = queue_frame(FR_TOKEN_OK, 8'h00, 2, 0, 0, 0);
        unused = queue_frame(FR_TLEN_BAD, 8'hFF, 3, 0, 0, 0);
        unused = queue_frame(FR_TOKEN_CUT, 8'h01, 0, 0, 0, 0);
        unused = queue_frame(FR_NOISE, 8'h00, 6, 0, 0, 20);

        load_token(TOK_RANDOM, 1'b1);
        unused = queue_frame(FR_TOKEN_OK, 8'hFF, 0, 0, 0, 0);
        unused = queue_frame(FR_TOKEN_OK, 8'h00, 4, 0, 2, 40);
        unused = queue_frame(FR_TOKEN_BAD, 8'h80, 1, 0, 0, 0);
        unused = queue_frame(FR_OPEN, 8'h00, 300, 0, 0, 0);
        unused = queue_frame(FR_TOKEN_OK, 8'h07, 3, 1, 0, 0);
        run_random(230);

        load_token(TOK_ONES, 1'b1);
        run_random(230);

        load_token(TOK_ZEROS, 1'b1);
        run_random(230);

        load_token(TOK_RANDOM, 1'b0);
        run_random(230);

        load_token(TOK_RANDOM, 1'b1);
        calm <= 1'b1;
        run_random(230);

        drain();
        repeat (6) @(posedge i_clk);
        if (faults == 0) begin
            $display("crc_framed_command_checker_tb OK");
        end else begin
            $display("crc_framed_command_checker_tb NOT OK");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/cfcc_pkg.sv
rtl/cfcc_frame.sv
rtl/cfcc_outbuf.sv
rtl/crc_framed_command_checker.sv
bench/crc_framed_command_checker_tb.sv
